[rtl/region_average_rgba_sampler_unit_defines.svh]
// Assertion macros shared by the checker of the region sampler.
`ifndef REGION_AVERAGE_RGBA_SAMPLER_UNIT_DEFINES_SVH
`define REGION_AVERAGE_RGBA_SAMPLER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define RAS_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);
// Implication whose consequent is checked in the following cycle.
`define RAS_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);
`endif

[rtl/ras_pkg.sv]
// Package with the shared types and constants of the region sampler.
`timescale 1ns / 1ps
package ras_pkg;
   localparam int unsigned AddrWidth = 14;
   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } opcode_type;
   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH   = 2'd0,
      REG_IMAGE_HEIGHT  = 2'd1,
      REG_CANVAS_WIDTH  = 2'd2,
      REG_CANVAS_HEIGHT = 2'd3
   } reg_index_type;
   typedef struct packed {
      logic       opcode;
      logic [13:0] pixel_index;
      logic [7:0] pixel_red;
      logic [7:0] pixel_green;
      logic [7:0] pixel_blue;
      logic [7:0] pixel_alpha;
      logic [11:0] sample_column;
      logic [11:0] sample_row;
      logic [12:0] grid_columns;
      logic [12:0] grid_rows;
   } req_word_type;
   typedef struct packed {
      logic [7:0] avg_red;
      logic [7:0] avg_green;
      logic [7:0] avg_blue;
      logic [7:0] avg_alpha;
      logic [7:0] avg_brightness;
      logic       region_valid;
   } rsp_word_type;
   // Control between the top level and the shared divider.
   typedef struct packed {
      logic        start;
      logic [35:0] dividend;
      logic [35:0] divisor;
   } div_req_type;
   typedef struct packed {
      logic        done;
      logic [35:0] quotient;
   } div_rsp_type;
   localparam int unsigned DivWidth = 36;
endpackage

[rtl/ras_stream_if.sv]
// Valid/ready stream interface for request and response words.
`timescale 1ns / 1ps
interface ras_stream_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/ras_ram.sv]
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module ras_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

[rtl/ras_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ras_divider (
   input  logic                clock,
   input  logic                reset,
   input  ras_pkg::div_req_type req,
   output ras_pkg::div_rsp_type rsp
);
   import ras_pkg::*;
   localparam int unsigned CntWidth = $clog2(DivWidth + 1);
   logic [DivWidth-1:0] quo_ff, quo_in;
   logic [DivWidth-1:0] rem_ff, rem_in;
   logic [DivWidth-1:0] den_ff, den_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DivWidth:0]   trial;
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DivWidth-1]} - {1'b0, den_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = CntWidth'(DivWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DivWidth]) begin
            rem_in = trial[DivWidth-1:0];
            quo_in = {quo_ff[DivWidth-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DivWidth-2:0], quo_ff[DivWidth-1]};
            quo_in = {quo_ff[DivWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

[rtl/region_average_rgba_sampler_unit.sv]
// Top level of the region-average RGBA sampler.
//
//   channel  direction  word            accepted when
//   req      in         req_word_type   req.valid && req.ready
//   rsp      out        rsp_word_type   rsp.valid && rsp.ready
//   csr      in         index + data    csr_wr_en
//
// A pixel write goes straight to the store on accept. A sample takes the span
// computation (four divisions on the shared divider), then a walk over each
// pixel of the clipped region and a drain through the registered store read
// and the per-pixel premultiply and luma stages, then five more divisions. A
// region that starts outside the image skips the walk and the last five
// divisions. The divider and the single store port bound the time of a
// sample. Reset is synchronous and clears the control state and the
// configuration registers; the pixel store is not cleared. A stalled response
// holds its word; no new request is taken until the result has been taken.
`timescale 1ns / 1ps
module region_average_rgba_sampler_unit #(
   parameter int unsigned MAX_PIXELS = 16384
) (
   input  logic        clock,
   input  logic        reset,
   ras_stream_if.sink  req,
   ras_stream_if.source rsp,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   import ras_pkg::*;

   localparam int unsigned RamAw = $clog2(MAX_PIXELS);
   // Reciprocal of 10000 scaled by 2^36, rounded up; exact for every luma sum.
   localparam logic [22:0] LumaRecip = 23'd6871948;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SPAN, ST_SPAN_WAIT, ST_SETUP, ST_WALK, ST_DRAIN,
      ST_DIV, ST_DIV_WAIT, ST_RESULT
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  img_w_ff, img_h_ff;
   logic [10:0] cnv_w_ff, cnv_h_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= 8'd1;
         img_h_ff <= 8'd1;
         cnv_w_ff <= 11'd1;
         cnv_h_ff <= 11'd1;
      end else if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            REG_IMAGE_WIDTH:   img_w_ff <= csr_data[7:0];
            REG_IMAGE_HEIGHT:  img_h_ff <= csr_data[7:0];
            REG_CANVAS_WIDTH:  cnv_w_ff <= csr_data;
            REG_CANVAS_HEIGHT: cnv_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   req_word_type q;
   assign q = req.data;
   logic accept;
   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;

   // Request holding registers.
   logic [11:0] col_ff, row_ff;
   logic [12:0] gc_ff, gr_ff;

   // Store access: one port shared by writes and the region walk.
   logic [31:0] rd_data;
   logic [RamAw-1:0] ram_addr;
   logic ram_we;
   logic [23:0] walk_addr_ff, walk_addr_in;
   logic [13:0] in_addr;
   assign in_addr = q.pixel_index;
   logic wr_ok;
   assign wr_ok = ({10'd0, in_addr} < 24'(MAX_PIXELS));
   assign ram_we = accept && (q.opcode == OP_WRITE) && wr_ok;
   always_comb begin
      if (state_ff == ST_WALK) begin
         ram_addr = walk_addr_ff[RamAw-1:0];
      end else begin
         ram_addr = RamAw'(in_addr);
      end
   end
   ras_ram #(.Width(32), .Depth(MAX_PIXELS)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data ({q.pixel_alpha, q.pixel_blue, q.pixel_green, q.pixel_red}),
      .rd_data (rd_data)
   );

   // Shared divider.
   div_req_type dreq;
   div_rsp_type drsp;
   ras_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Span results: 0 x0, 1 x1, 2 y0, 3 y1.
   logic [2:0]  step_ff, step_in;
   logic [23:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [23:0] x_ff, x_in, y_ff, y_in;
   logic [23:0] xe_ff, ye_ff;
   logic [35:0] count_ff;
   logic        vld_ff;

   // Span dividend: idx*canvas or (idx+1)*canvas + grid - 1.
   logic [12:0] sp_idx;
   logic [10:0] sp_cnv;
   logic [12:0] sp_grid;
   logic        sp_ceil;
   logic [23:0] sp_prod;
   always_comb begin
      sp_ceil = step_ff[0];
      if (step_ff[1]) begin
         sp_cnv  = cnv_h_ff;
         sp_grid = gr_ff;
         sp_idx  = {1'b0, row_ff} + {12'd0, sp_ceil};
      end else begin
         sp_cnv  = cnv_w_ff;
         sp_grid = gc_ff;
         sp_idx  = {1'b0, col_ff} + {12'd0, sp_ceil};
      end
      sp_prod = 24'(sp_idx) * 24'(sp_cnv);
   end

   // Per-pixel pipeline: read valid, premultiply, luma, accumulate.
   logic       rv1_ff, rv2_ff, rv3_ff, rv4_ff, rv5_ff;
   logic       pin_ff;
   logic [7:0] pr_ff, pg_ff, pb_ff, pa_ff;
   logic [15:0] mr_ff, mg_ff, mb_ff;
   logic [7:0]  a2_ff;
   logic [21:0] wsum_ff;
   logic [44:0] luma_prod;
   logic [7:0]  luma_ff;
   logic [15:0] ml_ff;
   logic [7:0]  a3_ff;
   logic [7:0]  dr_ff, dg_ff, db_ff;
   logic [35:0] sr_ff, sg_ff, sb_ff, sa_ff, sl_ff;
   logic [2:0]  drain_ff;
   logic [7:0]  res_ff [5];
   logic        rsp_valid_ff;

   // Divide by 255 of a 16-bit product: (v + 1 + (v >> 8)) >> 8.
   function automatic logic [7:0] div255(input logic [15:0] v);
      logic [16:0] t;
      t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
      return t[15:8];
   endfunction

   // The weighted sum divided by 10000 through a reciprocal multiplication.
   always_comb begin
      luma_prod = 45'(wsum_ff) * 45'(LumaRecip);
   end

   logic last_x;
   assign last_x = (x_ff + 24'd1 >= xe_ff);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      walk_addr_in = walk_addr_ff;
      dreq.start   = 1'b0;
      dreq.dividend = '0;
      dreq.divisor  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && q.opcode == OP_SAMPLE) begin
               state_in = ST_SPAN;
               step_in  = '0;
            end
         end
         ST_SPAN: begin
            dreq.start    = 1'b1;
            dreq.dividend = sp_ceil ? 36'(sp_prod) + 36'(sp_grid) - 36'd1 : 36'(sp_prod);
            dreq.divisor  = 36'(sp_grid);
            state_in      = ST_SPAN_WAIT;
         end
         ST_SPAN_WAIT: begin
            if (drsp.done) begin
               step_in  = step_ff + 3'd1;
               state_in = (step_ff == 3'd3) ? ST_SETUP : ST_SPAN;
            end
         end
         ST_SETUP: begin
            x_in = x0_ff;
            y_in = y0_ff;
            walk_addr_in = 24'(y0_ff[7:0] * img_w_ff) + x0_ff;
            // Only a region that starts inside the image is walked.
            state_in = (vld_ff && x0_ff < {16'd0, img_w_ff} && y0_ff < {16'd0, img_h_ff})
                       ? ST_WALK : ST_RESULT;
         end
         ST_WALK: begin
            if (last_x) begin
               x_in = x0_ff;
               y_in = y_ff + 24'd1;
               walk_addr_in = walk_addr_ff + 24'(img_w_ff) - (xe_ff - x0_ff) + 24'd1;
               if (y_ff + 24'd1 >= ye_ff) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               x_in = x_ff + 24'd1;
               walk_addr_in = walk_addr_ff + 24'd1;
            end
            step_in = '0;
         end
         ST_DRAIN: begin
            if (drain_ff == 3'd5) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            dreq.start   = 1'b1;
            dreq.divisor = count_ff;
            case (step_ff)
               3'd0:    dreq.dividend = sr_ff;
               3'd1:    dreq.dividend = sg_ff;
               3'd2:    dreq.dividend = sb_ff;
               3'd3:    dreq.dividend = sa_ff;
               default: dreq.dividend = sl_ff;
            endcase
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (drsp.done) begin
               step_in  = step_ff + 3'd1;
               state_in = (step_ff == 3'd4) ? ST_RESULT : ST_DIV;
            end
         end
         ST_RESULT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   logic [23:0] dq;
   assign dq = drsp.quotient[23:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rv1_ff       <= 1'b0;
         rv2_ff       <= 1'b0;
         rv3_ff       <= 1'b0;
         rv4_ff       <= 1'b0;
         rv5_ff       <= 1'b0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         rv1_ff   <= (state_ff == ST_WALK);
         rv2_ff   <= rv1_ff;
         rv3_ff   <= rv2_ff;
         rv4_ff   <= rv3_ff;
         rv5_ff   <= rv4_ff;
         drain_ff <= (state_ff == ST_DRAIN) ? drain_ff + 3'd1 : 3'd0;
         if (state_ff == ST_RESULT && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end else if (state_in == ST_RESULT && state_ff != ST_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end
      end
      x_ff <= x_in;
      y_ff <= y_in;
      walk_addr_ff <= walk_addr_in;
      if (accept) begin
         col_ff <= q.sample_column;
         row_ff <= q.sample_row;
         gc_ff  <= q.grid_columns;
         gr_ff  <= q.grid_rows;
         vld_ff <= 1'b1;
         sr_ff <= '0; sg_ff <= '0; sb_ff <= '0; sa_ff <= '0; sl_ff <= '0;
         for (int i = 0; i < 5; i++) res_ff[i] <= '0;
      end
      if (state_ff == ST_SPAN && (gc_ff == '0 || gr_ff == '0)) begin
         vld_ff <= 1'b0;
      end
      if (state_ff == ST_SPAN_WAIT && drsp.done) begin
         case (step_ff[1:0])
            2'd0: x0_ff <= dq;
            2'd1: x1_ff <= (dq <= x0_ff) ? x0_ff + 24'd1 : dq;
            2'd2: y0_ff <= dq;
            default: y1_ff <= (dq <= y0_ff) ? y0_ff + 24'd1 : dq;
         endcase
      end
      if (state_ff == ST_SETUP) begin
         count_ff <= 36'((x1_ff - x0_ff) * (y1_ff - y0_ff));
         xe_ff <= (x1_ff > {16'd0, img_w_ff}) ? {16'd0, img_w_ff} : x1_ff;
         ye_ff <= (y1_ff > {16'd0, img_h_ff}) ? {16'd0, img_h_ff} : y1_ff;
         if (gc_ff == '0 || gr_ff == '0 || x0_ff >= {16'd0, img_w_ff}
             || y0_ff >= {16'd0, img_h_ff}) begin
            vld_ff <= 1'b0;
         end
      end
      // Stage 1: register the pixel read by the store; addresses past the store read zero.
      pin_ff <= ({10'd0, walk_addr_ff[13:0]} == walk_addr_ff) &&
                (walk_addr_ff < 24'(MAX_PIXELS));
      {pa_ff, pb_ff, pg_ff, pr_ff} <= pin_ff ? rd_data : 32'd0;
      // Stage 2: products and the weighted luma sum.
      mr_ff <= pr_ff * pa_ff;
      mg_ff <= pg_ff * pa_ff;
      mb_ff <= pb_ff * pa_ff;
      a2_ff <= pa_ff;
      wsum_ff <= 22'(pr_ff) * 22'd2126 + 22'(pg_ff) * 22'd7152 + 22'(pb_ff) * 22'd722;
      // Stage 3: divide by 255 and the luma quotient.
      dr_ff <= div255(mr_ff);
      dg_ff <= div255(mg_ff);
      db_ff <= div255(mb_ff);
      luma_ff <= luma_prod[43:36];
      a3_ff <= a2_ff;
      // Stage 4: color and alpha sums, luma product.
      ml_ff <= luma_ff * a3_ff;
      if (rv4_ff) begin
         sr_ff <= sr_ff + 36'(dr_ff);
         sg_ff <= sg_ff + 36'(dg_ff);
         sb_ff <= sb_ff + 36'(db_ff);
         sa_ff <= sa_ff + 36'(a3_ff);
      end
      // Stage 5: luma sum.
      if (rv5_ff) begin
         sl_ff <= sl_ff + 36'(div255(ml_ff));
      end
      if (state_ff == ST_DIV_WAIT && drsp.done) begin
         res_ff[step_ff] <= dq[7:0];
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data.avg_red        = res_ff[0];
   assign rsp.data.avg_green      = res_ff[1];
   assign rsp.data.avg_blue       = res_ff[2];
   assign rsp.data.avg_alpha      = res_ff[3];
   assign rsp.data.avg_brightness = res_ff[4];
   assign rsp.data.region_valid   = vld_ff;
endmodule

[rtl/ras_checker.sv]
// Port-level checker for the region sampler, bound to the top level.
`timescale 1ns / 1ps
`include "region_average_rgba_sampler_unit_defines.svh"
module ras_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic region_valid,
   input logic [7:0] avg_alpha
);
   `RAS_ASSERT_IMP(a_no_take_while_out, clock, reset, rsp_valid, !req_ready, "request taken with result pending")
   `RAS_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && !region_valid, avg_alpha == 8'd0, "invalid region with nonzero alpha")
   `RAS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result dropped under stall")
endmodule

bind region_average_rgba_sampler_unit ras_checker u_ras_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .region_valid(rsp.data.region_valid), .avg_alpha(rsp.data.avg_alpha)
);
